// File: rtl/sha256_stream_hasher_unit_defines.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/shs_pkg.sv
// Shared types, constants and SHA-256 functions for the stream hasher.
package shs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } shs_state_t;

    typedef struct packed {
        logic shift_byte;
        logic step;
    } shs_sched_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic restart;
    } shs_core_ctl_t;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam logic [7:0][31:0] H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: sequencer, counters and digest output.
// Usage:
//   Item channel (item_valid / item_stall): one request carries data_byte,
//   byte_valid and message_end. A request with message_end set closes the
//   message after its byte, if any; an empty message is allowed.
//   Digest channel (digest_valid / digest_stall): eight requests per message,
//   digest_word with word_index 0 to 7, last_word set on word 7.
// Timing:
//   A byte that does not complete a block leaves the block idle. A byte that
//   completes a block starts a compression (load, 64 rounds of the
//   shared round unit, fold). At message end, padding bytes are shifted in
//   one per cycle (up to 64 per block), followed by one compression, or two
//   when the length no longer fits; then the eight digest words go out at
//   one per cycle while digest_stall is low.
//   item_stall is high from the first cycle after such work starts until the
//   block is back in idle.
// Reset: chaining words return to the initial hash values, byte and fill
//   counts clear, and the block comes up idle. After word 7 is taken the same
//   restart happens. While digest_stall is high the current word holds.
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        message_end,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shs_pkg::*;

    shs_state_t       state_reg;
    shs_state_t       state_next;
    logic [5:0]       fill_reg;
    logic [5:0]       fill_next;
    logic [60:0]      count_reg;
    logic [60:0]      count_next;
    logic [5:0]       round_reg;
    logic [5:0]       round_next;
    logic [2:0]       word_reg;
    logic [2:0]       word_next;
    logic             end_reg;
    logic             end_next;
    logic             first_reg;
    logic             first_next;
    logic             len_ok_reg;
    logic             len_ok_next;

    logic             item_take;
    logic             digest_take;
    logic [7:0][7:0]  len_bytes;
    logic [7:0]       pad_byte;
    logic [7:0]       sched_byte;
    shs_sched_ctl_t   sched_ctl;
    shs_core_ctl_t    core_ctl;
    logic [31:0]      w_cur;
    logic [7:0][31:0] chain;

    assign item_take   = item_valid && !item_stall;
    assign digest_take = digest_valid && !digest_stall;
    assign len_bytes   = {count_reg, 3'b000};

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ok_reg && (fill_reg >= LEN_OFFSET))
        begin
            pad_byte = len_bytes[~fill_reg[2:0]];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if (byte_valid && (fill_reg == LAST_SLOT))
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_ok_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (digest_take && (word_reg == LAST_WORD))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and unit controls
    always_comb
    begin
        item_stall           = (state_reg != ST_IDLE);
        digest_valid         = (state_reg == ST_EMIT);
        sched_ctl.shift_byte = ((state_reg == ST_IDLE) && item_valid && byte_valid)
                             || (state_reg == ST_PAD);
        sched_ctl.step       = (state_reg == ST_ROUND);
        sched_byte           = (state_reg == ST_PAD) ? pad_byte : data_byte;
        core_ctl.load        = (state_reg == ST_LOAD);
        core_ctl.step        = (state_reg == ST_ROUND);
        core_ctl.fold        = (state_reg == ST_FOLD);
        core_ctl.restart     = (state_reg == ST_EMIT) && !digest_stall
                             && (word_reg == LAST_WORD);
    end

    // counters and padding flags
    always_comb
    begin
        fill_next   = fill_reg;
        count_next  = count_reg;
        round_next  = round_reg;
        word_next   = word_reg;
        end_next    = end_reg;
        first_next  = first_reg;
        len_ok_next = len_ok_reg;
        if (sched_ctl.shift_byte)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (item_take)
        begin
            end_next    = message_end;
            first_next  = 1'b1;
            len_ok_next = 1'b0;
            if (byte_valid)
            begin
                count_next = count_reg + 61'd1;
            end
        end
        if (state_reg == ST_PAD)
        begin
            first_next = 1'b0;
            if (first_reg)
            begin
                len_ok_next = (fill_reg < LEN_OFFSET);
            end
        end
        if ((state_reg == ST_FOLD) && end_reg && !first_reg)
        begin
            len_ok_next = 1'b1;
        end
        if (state_reg == ST_LOAD)
        begin
            round_next = 6'd0;
        end
        else if (state_reg == ST_ROUND)
        begin
            round_next = round_reg + 6'd1;
        end
        if (digest_take)
        begin
            word_next = word_reg + 3'd1;
        end
        if (core_ctl.restart)
        begin
            fill_next  = 6'd0;
            count_next = 61'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            count_reg  <= 61'd0;
            round_reg  <= 6'd0;
            word_reg   <= 3'd0;
            end_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            round_reg  <= round_next;
            word_reg   <= word_next;
            end_reg    <= end_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
        end
    end

    shs_sched u_sched (
        .clk     (clk),
        .ctl     (sched_ctl),
        .byte_in (sched_byte),
        .w_cur   (w_cur)
    );

    shs_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (core_ctl),
        .round_idx (round_reg),
        .w_cur     (w_cur),
        .chain     (chain)
    );

    assign digest_word = chain[word_reg];
    assign word_index  = word_reg;
    assign last_word   = (word_reg == LAST_WORD);

`include "sha256_stream_hasher_unit_defines.svh"

    `SHS_ASSERT_NOW(a_emit_blocks_items, digest_valid, item_stall, "item taken during digest output")
    `SHS_ASSERT_NOW(a_emit_block_aligned, state_reg == ST_EMIT, fill_reg == 6'd0, "digest with partial block")
    `SHS_ASSERT_NEXT(a_rounds_then_fold, (state_reg == ST_ROUND) && (round_reg == LAST_ROUND), state_reg == ST_FOLD, "round count overrun")
    `SHS_ASSERT_NEXT(a_restart_clears, digest_take && last_word, (count_reg == 61'd0) && (state_reg == ST_IDLE), "no restart after last word")

endmodule

// File: rtl/shs_sched.sv
// Block buffer and message schedule window: byte shift-in and word expansion.
module shs_sched (
    input  logic                   clk,
    input  shs_pkg::shs_sched_ctl_t ctl,
    input  logic [7:0]             byte_in,
    output logic [31:0]            w_cur
);
    import shs_pkg::*;

    logic [15:0][31:0] win_reg;
    logic [15:0][31:0] win_next;
    logic [31:0]       w_new;

    // window slot 15 holds the oldest word
    always_comb
    begin
        w_new = win_reg[15] + small_sigma0(win_reg[14]) + win_reg[6]
              + small_sigma1(win_reg[1]);
    end

    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift_byte)
        begin
            win_next = {win_reg[15][23:0], win_reg[14:0], byte_in};
        end
        else if (ctl.step)
        begin
            win_next = {win_reg[14:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign w_cur = win_reg[15];

endmodule

// File: rtl/shs_round.sv
// Compression round unit: working variables and chaining words.
module shs_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  shs_pkg::shs_core_ctl_t ctl,
    input  logic [5:0]             round_idx,
    input  logic [31:0]            w_cur,
    output logic [7:0][31:0]       chain
);
    import shs_pkg::*;

    logic [7:0][31:0] work_reg;
    logic [7:0][31:0] work_next;
    logic [7:0][31:0] chain_reg;
    logic [7:0][31:0] chain_next;
    logic [31:0]      t1;
    logic [31:0]      t2;
    logic [31:0]      ch;
    logic [31:0]      maj;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + round_k(round_idx) + w_cur;
        t2  = big_sigma0(work_reg[0]) + maj;
    end

    always_comb
    begin
        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = chain_reg;
        end
        else if (ctl.step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctl.restart)
        begin
            chain_next = H_INIT;
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= H_INIT;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule
